[rtl/sstf_pkg.sv]
// sstf_pkg: shared constants, types and command/status structs of the
// shortest-seek-first request scheduler
// no dependencies
package sstf_pkg;

   localparam int MAX_REQUESTS  = 32;
   localparam int CYLINDER_BITS = 16;

   localparam int IDX_BITS  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS  = $clog2(MAX_REQUESTS + 1);
   localparam int MOVE_BITS = 22;
   localparam int SUM_BITS  = ((CYLINDER_BITS > MOVE_BITS) ? CYLINDER_BITS : MOVE_BITS) + 1;

   localparam logic [MOVE_BITS-1:0] MOVE_MAX = {MOVE_BITS{1'b1}};

   typedef logic [CYLINDER_BITS-1:0] cyl_type;
   typedef logic [IDX_BITS-1:0]      idx_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;
   typedef logic [MOVE_BITS-1:0]     move_type;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_RUN  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EMPTY_OUT,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic scan_begin;
      logic decide;
      logic emit;
      logic empty_emit;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_done;
      logic last_pick;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/sstf_disk_request_scheduler_core.sv]
// sstf_disk_request_scheduler_core: top level, controller plus datapath
// depends on sstf_pkg, sstf_ctrl, sstf_datapath
//
// A load item (op 0) appends a cylinder to a queue of
// MAX_REQUESTS entries; loads into a full queue are dropped. A run item
// (op 1) serves the n queued requests nearest-first and emits one result per
// visit. Each visit scans all n loaded entries through the single read port
// of the request memory, one entry per cycle, then picks and updates.
// A run with an empty queue emits one result, flagged empty.
// Inputs are taken only between runs; the result register lets the next
// scan proceed while a result waits for transfer.
module sstf_disk_request_scheduler_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_cylinder_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_head_position,
   output logic [5:0]  rsp_arrival_number,
   output logic [21:0] rsp_total_moved,
   output logic        rsp_last_visit,
   output logic        rsp_queue_empty
);
   import sstf_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   sstf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sstf_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .req_cylinder_value (req_cylinder_value),
      .cmd                (cmd),
      .status             (status),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_head_position  (rsp_head_position),
      .rsp_arrival_number (rsp_arrival_number),
      .rsp_total_moved    (rsp_total_moved),
      .rsp_last_visit     (rsp_last_visit),
      .rsp_queue_empty    (rsp_queue_empty)
   );

endmodule

[rtl/sstf_ctrl.sv]
// sstf_ctrl: sequencer for loads, scan passes, picks and result transfers
// depends on sstf_pkg
module sstf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_op,
   output logic                   req_stall,
   input  sstf_pkg::dp_status_type status,
   output sstf_pkg::dp_cmd_type    cmd
);
   import sstf_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = reset;
            if (req_valid && !reset) begin
               if (req_op == OP_RUN) begin
                  cmd.start = 1'b1;
                  if (status.count_zero) begin
                     state_in = ST_EMPTY_OUT;
                  end else begin
                     cmd.scan_begin = 1'b1;
                     state_in       = ST_SCAN;
                  end
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_EMPTY_OUT: begin
            if (status.out_free) begin
               cmd.empty_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.last_pick) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.scan_begin = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/sstf_datapath.sv]
// sstf_datapath: request memory, pending bits, nearest-candidate scan,
// pick and movement accumulation, result register
// depends on sstf_pkg
module sstf_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             req_cylinder_value,
   input  sstf_pkg::dp_cmd_type    cmd,
   output sstf_pkg::dp_status_type status,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [15:0]             rsp_head_position,
   output logic [5:0]              rsp_arrival_number,
   output logic [21:0]             rsp_total_moved,
   output logic                    rsp_last_visit,
   output logic                    rsp_queue_empty
);
   import sstf_pkg::*;

   cyl_type                 req_mem [MAX_REQUESTS];
   logic [MAX_REQUESTS-1:0] pend_ff;
   cnt_type                 count_ff;
   cnt_type                 remain_ff;
   cyl_type                 head_ff;
   move_type                total_ff;

   idx_type addr_ff;
   logic    issue_ff;
   logic    rd_live_ff;
   logic    rd_pend_ff;
   idx_type rd_idx_ff;
   cyl_type rd_data_ff;

   logic    have_up_ff;
   logic    have_dn_ff;
   idx_type up_idx_ff;
   idx_type dn_idx_ff;
   cyl_type up_cyl_ff;
   cyl_type dn_cyl_ff;

   idx_type pick_idx_ff;
   cyl_type pick_cyl_ff;
   cyl_type dist_ff;

   logic    rsp_valid_ff;
   cyl_type out_head_ff;
   idx_type out_idx_ff;
   move_type out_total_ff;
   logic    out_last_ff;
   logic    out_empty_ff;

   cyl_type             val;
   logic                issue_last;
   logic                out_free;
   cyl_type             du;
   cyl_type             dd;
   logic                take_up;
   logic [SUM_BITS-1:0] sum;
   move_type            total_in;

   assign val        = CYLINDER_BITS'(req_cylinder_value);
   assign issue_last = (CNT_BITS'(addr_ff) + CNT_BITS'(1)) == count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign du         = up_cyl_ff - head_ff;
   assign dd         = head_ff - dn_cyl_ff;
   assign sum        = SUM_BITS'(total_ff) + SUM_BITS'(dist_ff);
   assign total_in   = (sum > SUM_BITS'(MOVE_MAX)) ? MOVE_MAX : MOVE_BITS'(sum);

   always_comb begin
      if (have_up_ff && have_dn_ff) begin
         if (du < dd) begin
            take_up = 1'b1;
         end else if (du > dd) begin
            take_up = 1'b0;
         end else begin
            take_up = up_idx_ff < dn_idx_ff;
         end
      end else begin
         take_up = have_up_ff;
      end
   end

   assign status.count_zero = count_ff == '0;
   assign status.scan_done  = !issue_ff && !rd_live_ff;
   assign status.last_pick  = remain_ff == CNT_BITS'(1);
   assign status.out_free   = out_free;

   // request memory
   always_ff @(posedge clock) begin
      if (cmd.load && count_ff != CNT_BITS'(MAX_REQUESTS)) begin
         req_mem[count_ff[IDX_BITS-1:0]] <= val;
      end
      if (issue_ff) begin
         rd_data_ff <= req_mem[addr_ff];
      end
   end

   // queue bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= '0;
         count_ff  <= '0;
         remain_ff <= '0;
         head_ff   <= '0;
         total_ff  <= '0;
      end else begin
         if (cmd.load && count_ff != CNT_BITS'(MAX_REQUESTS)) begin
            pend_ff[count_ff[IDX_BITS-1:0]] <= 1'b1;
            count_ff                        <= count_ff + CNT_BITS'(1);
         end
         if (cmd.start) begin
            head_ff   <= val;
            total_ff  <= '0;
            remain_ff <= count_ff;
         end
         if (cmd.empty_emit) begin
            count_ff <= '0;
         end
         if (cmd.emit) begin
            head_ff   <= pick_cyl_ff;
            total_ff  <= total_in;
            remain_ff <= remain_ff - CNT_BITS'(1);
            if (status.last_pick) begin
               pend_ff  <= '0;
               count_ff <= '0;
            end else begin
               pend_ff[pick_idx_ff] <= 1'b0;
            end
         end
      end
   end

   // scan control
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff   <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         rd_live_ff <= issue_ff;
         if (cmd.scan_begin) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && issue_last) begin
            issue_ff <= 1'b0;
         end
      end
   end

   // scan payload and nearest candidates
   always_ff @(posedge clock) begin
      if (cmd.scan_begin) begin
         addr_ff    <= '0;
         have_up_ff <= 1'b0;
         have_dn_ff <= 1'b0;
      end else begin
         if (issue_ff) begin
            addr_ff    <= addr_ff + IDX_BITS'(1);
            rd_idx_ff  <= addr_ff;
            rd_pend_ff <= pend_ff[addr_ff];
         end
         if (rd_live_ff && rd_pend_ff) begin
            if (rd_data_ff > head_ff) begin
               if (!have_up_ff || rd_data_ff < up_cyl_ff) begin
                  have_up_ff <= 1'b1;
                  up_cyl_ff  <= rd_data_ff;
                  up_idx_ff  <= rd_idx_ff;
               end
            end else begin
               if (!have_dn_ff || rd_data_ff >= dn_cyl_ff) begin
                  have_dn_ff <= 1'b1;
                  dn_cyl_ff  <= rd_data_ff;
                  dn_idx_ff  <= rd_idx_ff;
               end
            end
         end
      end
   end

   // pick
   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         if (take_up) begin
            pick_idx_ff <= up_idx_ff;
            pick_cyl_ff <= up_cyl_ff;
            dist_ff     <= du;
         end else begin
            pick_idx_ff <= dn_idx_ff;
            pick_cyl_ff <= dn_cyl_ff;
            dist_ff     <= dd;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit || cmd.empty_emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_head_ff  <= pick_cyl_ff;
         out_idx_ff   <= pick_idx_ff;
         out_total_ff <= total_in;
         out_last_ff  <= status.last_pick;
         out_empty_ff <= 1'b0;
      end else if (cmd.empty_emit) begin
         out_head_ff  <= head_ff;
         out_idx_ff   <= '0;
         out_total_ff <= '0;
         out_last_ff  <= 1'b1;
         out_empty_ff <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_head_position  = 16'(out_head_ff);
   assign rsp_arrival_number = 6'(out_idx_ff);
   assign rsp_total_moved    = out_total_ff;
   assign rsp_last_visit     = out_last_ff;
   assign rsp_queue_empty    = out_empty_ff;

endmodule
